// ===== sv/gn2_pkg.sv =====
package gn2_pkg;

   localparam int unsigned TABLE_BITS = 8;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned ADDR_W     = 3;

   localparam logic [15:0] FREQ_RESET = 16'd3277;

   typedef enum logic {
      CMD_EVAL = 1'b0,
      CMD_LOAD = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      REG_FREQUENCY = 1'b0,
      REG_NONE      = 1'b1
   } reg_index_type;

   // improved gradient set: 12 cube-edge vectors, 4 repeated
   function automatic logic signed [18:0] grad_dot(input logic [3:0] h,
                                                   input logic signed [16:0] dx,
                                                   input logic signed [16:0] dy);
      logic signed [18:0] u;
      logic signed [18:0] v;
      u = (h < 4'd8) ? 19'(dx) : 19'(dy);
      if (h < 4'd4) begin
         v = 19'(dy);
      end else if (h == 4'd12 || h == 4'd14) begin
         v = 19'(dx);
      end else begin
         v = '0;
      end
      if (h[0]) begin
         u = -u;
      end
      if (h[1]) begin
         v = -v;
      end
      return u + v;
   endfunction

endpackage

// ===== sv/gn2_perm_ram.sv =====
module gn2_perm_ram
   import gn2_pkg::*;
(
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [TABLE_BITS-1:0] wr_addr,
   input  logic [7:0]            wr_data,
   input  logic                  rd_en,
   input  logic [TABLE_BITS-1:0] rd_addr,
   output logic [7:0]            rd_data
);

   logic [7:0] mem [0:(1<<TABLE_BITS)-1];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/gradient_noise_2d_top.sv =====
// An accepted evaluate beat passes through the stage registers and the output register to its result beat.
// Throughput: one beat per cycle while rsp_ready holds; the six table copies give each hash read its own port.
// Load beats write the table copies as they pass the read stages, so order is kept.
// Reset clears stage valids and sets frequency to 3277.
// The permutation table is undefined until written; no clearing pass.
module gradient_noise_2d_top
   import gn2_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic signed [15:0] req_x_coord,
   input  logic signed [15:0] req_y_coord,
   input  logic [7:0]         req_entry_index,
   input  logic [7:0]         req_entry_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_noise_value,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   reg_index_type csr_idx;
   logic [15:0] freq_ff, freq_in;

   assign csr_idx    = reg_index_type'(csr_paddr[ADDR_W-1]);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == '0) ? {16'd0, freq_ff} : 32'd0;

   always_comb begin
      freq_in = freq_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00
          && csr_idx == REG_FREQUENCY) begin
         freq_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= FREQ_RESET;
      end else begin
         freq_ff <= freq_in;
      end
   end

   // stage valids and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5, en6, en7, en_out;

   assign en_out    = !rsp_valid_ff || rsp_ready;
   assign en7       = !v7_ff || en_out;
   assign en6       = !v6_ff || en7;
   assign en5       = !v5_ff || en6;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;
   assign rsp_valid = rsp_valid_ff;

   cmd_type c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff, c7_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
         if (en7) v7_ff <= v6_ff;
         if (en_out) rsp_valid_ff <= v7_ff && (c7_ff == CMD_EVAL);
      end
   end

   // stage 1: scale
   logic signed [32:0] px_in, py_in;
   logic [31:0] px1_ff, py1_ff;
   logic [7:0]  idx1_ff, val1_ff, idx2_ff, val2_ff;

   assign px_in = req_x_coord * $signed({1'b0, freq_ff});
   assign py_in = req_y_coord * $signed({1'b0, freq_ff});

   always_ff @(posedge clock) begin
      if (en1) begin
         c1_ff   <= cmd_type'(req_cmd);
         px1_ff  <= px_in[31:0];
         py1_ff  <= py_in[31:0];
         idx1_ff <= req_entry_index;
         val1_ff <= req_entry_value;
      end
   end

   // stage 2: first hash read, t^2
   logic [7:0]  cx1, cy1, a2, b2;
   logic [15:0] fx1, fy1;
   logic [32:0] sqx, sqy;
   logic [7:0]  cy2_ff;
   logic [15:0] fx2_ff, fy2_ff, t2x2_ff, t2y2_ff;
   logic        wr_ab;

   assign cx1   = px1_ff[23:16];
   assign cy1   = py1_ff[23:16];
   assign fx1   = px1_ff[15:0];
   assign fy1   = py1_ff[15:0];
   assign sqx   = 33'(fx1) * 33'(fx1) + 33'd32768;
   assign sqy   = 33'(fy1) * 33'(fy1) + 33'd32768;
   assign wr_ab = v1_ff && (c1_ff == CMD_LOAD) && en2;

   gn2_perm_ram u_ram_a (
      .clock(clock), .wr_en(wr_ab), .wr_addr(idx1_ff), .wr_data(val1_ff),
      .rd_en(en2), .rd_addr(cx1), .rd_data(a2)
   );
   gn2_perm_ram u_ram_b (
      .clock(clock), .wr_en(wr_ab), .wr_addr(idx1_ff), .wr_data(val1_ff),
      .rd_en(en2), .rd_addr(cx1 + 8'd1), .rd_data(b2)
   );

   always_ff @(posedge clock) begin
      if (en2) begin
         c2_ff   <= c1_ff;
         idx2_ff <= idx1_ff;
         val2_ff <= val1_ff;
         cy2_ff  <= cy1;
         fx2_ff  <= fx1;
         fy2_ff  <= fy1;
         t2x2_ff <= sqx[31:16];
         t2y2_ff <= sqy[31:16];
      end
   end

   // stage 3: corner hash reads, t^3 and fade inner term
   logic [7:0]  h00, h10, h01, h11;
   logic [32:0] cbx, cby;
   logic [21:0] inx, iny;
   logic [15:0] fx3_ff, fy3_ff, t3x3_ff, t3y3_ff;
   logic [19:0] inx3_ff, iny3_ff;
   logic        wr_c;

   assign cbx  = 33'(t2x2_ff) * 33'(fx2_ff) + 33'd32768;
   assign cby  = 33'(t2y2_ff) * 33'(fy2_ff) + 33'd32768;
   assign inx  = 22'd655360 + 22'd6 * 22'(t2x2_ff) - 22'd15 * 22'(fx2_ff);
   assign iny  = 22'd655360 + 22'd6 * 22'(t2y2_ff) - 22'd15 * 22'(fy2_ff);
   assign wr_c = v2_ff && (c2_ff == CMD_LOAD) && en3;

   gn2_perm_ram u_ram_00 (
      .clock(clock), .wr_en(wr_c), .wr_addr(idx2_ff), .wr_data(val2_ff),
      .rd_en(en3), .rd_addr(a2 + cy2_ff), .rd_data(h00)
   );
   gn2_perm_ram u_ram_10 (
      .clock(clock), .wr_en(wr_c), .wr_addr(idx2_ff), .wr_data(val2_ff),
      .rd_en(en3), .rd_addr(b2 + cy2_ff), .rd_data(h10)
   );
   gn2_perm_ram u_ram_01 (
      .clock(clock), .wr_en(wr_c), .wr_addr(idx2_ff), .wr_data(val2_ff),
      .rd_en(en3), .rd_addr(a2 + cy2_ff + 8'd1), .rd_data(h01)
   );
   gn2_perm_ram u_ram_11 (
      .clock(clock), .wr_en(wr_c), .wr_addr(idx2_ff), .wr_data(val2_ff),
      .rd_en(en3), .rd_addr(b2 + cy2_ff + 8'd1), .rd_data(h11)
   );

   always_ff @(posedge clock) begin
      if (en3) begin
         c3_ff   <= c2_ff;
         fx3_ff  <= fx2_ff;
         fy3_ff  <= fy2_ff;
         t3x3_ff <= cbx[31:16];
         t3y3_ff <= cby[31:16];
         inx3_ff <= inx[19:0];
         iny3_ff <= iny[19:0];
      end
   end

   // stage 4: gradients, fade
   logic signed [16:0] dx0, dx1, dy0, dy1;
   logic [36:0] fdx, fdy;
   logic signed [18:0] g00_4_ff, g10_4_ff, g01_4_ff, g11_4_ff;
   logic [16:0] sx4_ff, sy4_ff;

   assign dx0 = $signed({1'b0, fx3_ff});
   assign dy0 = $signed({1'b0, fy3_ff});
   assign dx1 = dx0 - 17'sh10000;
   assign dy1 = dy0 - 17'sh10000;
   assign fdx = 37'(t3x3_ff) * 37'(inx3_ff) + 37'd32768;
   assign fdy = 37'(t3y3_ff) * 37'(iny3_ff) + 37'd32768;

   always_ff @(posedge clock) begin
      if (en4) begin
         c4_ff    <= c3_ff;
         g00_4_ff <= grad_dot(h00[3:0], dx0, dy0);
         g10_4_ff <= grad_dot(h10[3:0], dx1, dy0);
         g01_4_ff <= grad_dot(h01[3:0], dx0, dy1);
         g11_4_ff <= grad_dot(h11[3:0], dx1, dy1);
         sx4_ff   <= fdx[32:16];
         sy4_ff   <= fdy[32:16];
      end
   end

   // stage 5: x lerp products
   logic signed [19:0] dtop, dbot;
   logic signed [17:0] sxs;
   logic signed [37:0] pt5_ff, pb5_ff;
   logic signed [18:0] g00_5_ff, g01_5_ff;
   logic [16:0] sy5_ff, sy6_ff;

   assign dtop = 20'(g10_4_ff) - 20'(g00_4_ff);
   assign dbot = 20'(g11_4_ff) - 20'(g01_4_ff);
   assign sxs  = $signed({1'b0, sx4_ff});

   always_ff @(posedge clock) begin
      if (en5) begin
         c5_ff    <= c4_ff;
         pt5_ff   <= 38'(dtop) * 38'(sxs);
         pb5_ff   <= 38'(dbot) * 38'(sxs);
         g00_5_ff <= g00_4_ff;
         g01_5_ff <= g01_4_ff;
         sy5_ff   <= sy4_ff;
      end
   end

   // stage 6: x lerp sums
   logic signed [37:0] rt, rb;
   logic signed [21:0] top6_ff, bot6_ff;

   assign rt = (pt5_ff + 38'sd32768) >>> 16;
   assign rb = (pb5_ff + 38'sd32768) >>> 16;

   always_ff @(posedge clock) begin
      if (en6) begin
         c6_ff   <= c5_ff;
         top6_ff <= 22'(g00_5_ff) + rt[21:0];
         bot6_ff <= 22'(g01_5_ff) + rb[21:0];
         sy6_ff  <= sy5_ff;
      end
   end

   // stage 7: y lerp product
   logic signed [22:0] dy_n;
   logic signed [40:0] pm7_ff;
   logic signed [21:0] top7_ff;

   assign dy_n = 23'(bot6_ff) - 23'(top6_ff);

   always_ff @(posedge clock) begin
      if (en7) begin
         c7_ff   <= c6_ff;
         pm7_ff  <= 41'(dy_n) * 41'($signed({1'b0, sy6_ff}));
         top7_ff <= top6_ff;
      end
   end

   // output: y lerp sum, map to [0,1], clamp
   logic signed [40:0] rm;
   logic signed [23:0] n_val, w_val;
   logic [15:0] noise_in, noise_ff;

   assign rm    = (pm7_ff + 41'sd32768) >>> 16;
   assign n_val = 24'(top7_ff) + 24'(rm) + 24'sd65537;
   assign w_val = n_val >>> 1;

   always_comb begin
      if (w_val < 0) begin
         noise_in = 16'd0;
      end else if (w_val > 24'sd65535) begin
         noise_in = 16'hFFFF;
      end else begin
         noise_in = w_val[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         noise_ff <= noise_in;
      end
   end

   assign rsp_noise_value = noise_ff;

endmodule

// ===== verif/tb.sv =====
module tb;
   import gn2_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_cmd = CMD_EVAL;
   logic signed [15:0] req_x_coord = '0;
   logic signed [15:0] req_y_coord = '0;
   logic [7:0]         req_entry_index = '0;
   logic [7:0]         req_entry_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [15:0]        rsp_noise_value;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]  csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   gradient_noise_2d_top u_top (.*);

   logic [7:0]  perm_copy [256];
   logic [15:0] freq_copy;
   logic [15:0] noise_queue [$];
   int          mismatches = 0;
   int          cycles = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_off = 0;

   initial forever #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic longint rnd16(longint v);
      return (v + 32768) >>> 16;
   endfunction

   function automatic longint fade(longint t);
      longint t2;
      longint t3;
      t2 = rnd16(t * t);
      t3 = rnd16(t2 * t);
      return rnd16(t3 * (6 * t2 - 15 * t + 10 * 65536));
   endfunction

   function automatic longint corner_dot(logic [7:0] hash, longint dx, longint dy);
      logic [3:0] h;
      longint     u;
      longint     v;
      h = hash[3:0];
      u = (h < 8) ? dx : dy;
      v = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : 0);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

   function automatic logic [15:0] noise_at(logic signed [15:0] x, logic signed [15:0] y);
      longint     px, py, fx, fy, sx, sy, g00, g10, g01, g11, top, bot, n, w;
      logic [7:0] cx, cy, a, b;
      px = longint'(x) * longint'({1'b0, freq_copy});
      py = longint'(y) * longint'({1'b0, freq_copy});
      cx = px[23:16];
      cy = py[23:16];
      fx = longint'(px[15:0]);
      fy = longint'(py[15:0]);
      sx = fade(fx);
      sy = fade(fy);
      a = perm_copy[cx];
      b = perm_copy[8'(cx + 8'd1)];
      g00 = corner_dot(perm_copy[8'(a + cy)], fx, fy);
      g10 = corner_dot(perm_copy[8'(b + cy)], fx - 65536, fy);
      g01 = corner_dot(perm_copy[8'(a + cy + 8'd1)], fx, fy - 65536);
      g11 = corner_dot(perm_copy[8'(b + cy + 8'd1)], fx - 65536, fy - 65536);
      top = g00 + rnd16(sx * (g10 - g00));
      bot = g01 + rnd16(sx * (g11 - g01));
      n = top + rnd16(sy * (bot - top));
      w = ((n + 65536) * 32768 + 32768) >>> 16;
      if (w < 0) w = 0;
      if (w > 65535) w = 65535;
      return w[15:0];
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch: %s got %0d expected %0d", what, got, want);
      mismatches++;
   endtask

   // model tracking and result checking
   always @(posedge clock) begin
      if (reset) begin
         freq_copy = FREQ_RESET;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[ADDR_W-1:2] == REG_FREQUENCY) begin
            freq_copy = csr_pwdata[15:0];
         end
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_LOAD) begin
               perm_copy[req_entry_index] = req_entry_value;
            end else begin
               noise_queue.push_back(noise_at(req_x_coord, req_y_coord));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (noise_queue.size() == 0) begin
               report_mismatch("unexpected beat", rsp_noise_value, 16'd0);
            end else if (rsp_noise_value !== noise_queue[0]) begin
               report_mismatch("noise_value", rsp_noise_value, noise_queue[0]);
               void'(noise_queue.pop_front());
            end else begin
               void'(noise_queue.pop_front());
            end
         end
      end
   end

   // receiver
   initial forever begin
      @(negedge clock);
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_beat(cmd_type cmd, logic [15:0] x, logic [15:0] y,
                            logic [7:0] idx, logic [7:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_x_coord <= x;
      req_y_coord <= y;
      req_entry_index <= idx;
      req_entry_value <= val;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_eval(logic [15:0] x, logic [15:0] y);
      send_beat(CMD_EVAL, x, y, 8'($urandom), 8'($urandom));
   endtask

   task automatic send_load(logic [7:0] idx, logic [7:0] val);
      send_beat(CMD_LOAD, 16'($urandom), 16'($urandom), idx, val);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      wait (noise_queue.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] data);
      drain();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= ADDR_W'(idx) << 2;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic test_table_fill();
      logic [7:0] shuffle [256];
      logic [7:0] tmp;
      int         j;
      for (int i = 0; i < 256; i++) shuffle[i] = 8'(i);
      for (int i = 255; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = shuffle[i];
         shuffle[i] = shuffle[j];
         shuffle[j] = tmp;
      end
      for (int i = 0; i < 256; i++) send_load(8'(i), shuffle[i]);
      send_load(8'd0, 8'd255);
      send_load(8'd255, 8'd0);
   endtask

   task automatic test_extremes();
      logic [15:0] pts [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
      for (int i = 0; i < 5; i++)
         for (int k = 0; k < 5; k++) send_eval(pts[i], pts[k]);
      write_reg(REG_FREQUENCY, 32'd65535);
      send_eval(16'h7FFF, 16'h8000);
      send_eval(16'h8000, 16'h7FFF);
      send_eval(16'h0100, 16'hFF00);
      write_reg(REG_FREQUENCY, 32'd0);
      send_eval(16'h1234, 16'h8765);
      write_reg(REG_NONE, 32'hFFFF_FFFF);
      send_eval(16'h7FFF, 16'h7FFF);
   endtask

   task automatic random_phase(int beats, int idle, int stall, logic [15:0] freq);
      write_reg(REG_FREQUENCY, {16'($urandom), freq});
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < beats; i++) begin
         if ($urandom_range(9) == 0) send_load(8'($urandom), 8'($urandom));
         else send_eval(16'($urandom), 16'($urandom));
      end
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_random();
      random_phase(350, 0, 0, 16'($urandom));
      random_phase(350, 68, 0, 16'hFFFF);
      random_phase(350, 0, 68, 16'($urandom_range(4000)));
      random_phase(350, 9, 9, 16'($urandom));
      random_phase(100, 0, 0, FREQ_RESET);
   endtask

   task automatic test_backpressure();
      drain();
      hold_off = 300;
      for (int i = 0; i < 60; i++) send_eval(16'($urandom), 16'($urandom));
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_table_fill();
      test_extremes();
      test_backpressure();
      test_random();
      drain();
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
